>>> sv/uwbd_pkg.sv
// Package with word-break class codes, predicates and the context state type.
`default_nettype none

package uwbd_pkg;

    typedef logic [4:0] class_t;

    localparam class_t CLS_OTHER     = 5'd0;
    localparam class_t CLS_CR        = 5'd1;
    localparam class_t CLS_LF        = 5'd2;
    localparam class_t CLS_NEWLINE   = 5'd3;
    localparam class_t CLS_EXTEND    = 5'd4;
    localparam class_t CLS_ZWJ       = 5'd5;
    localparam class_t CLS_RI        = 5'd6;
    localparam class_t CLS_FORMAT    = 5'd7;
    localparam class_t CLS_KATAKANA  = 5'd8;
    localparam class_t CLS_HEBREW    = 5'd9;
    localparam class_t CLS_ALETTER   = 5'd10;
    localparam class_t CLS_SQ        = 5'd11;
    localparam class_t CLS_DQ        = 5'd12;
    localparam class_t CLS_MIDNUMLET = 5'd13;
    localparam class_t CLS_MIDLETTER = 5'd14;
    localparam class_t CLS_MIDNUM    = 5'd15;
    localparam class_t CLS_NUMERIC   = 5'd16;
    localparam class_t CLS_EXTNUMLET = 5'd17;
    localparam class_t CLS_WSEGSPACE = 5'd18;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 8;

    // Context carried from one codepoint to the next.
    typedef struct packed {
        class_t raw_prev;
        class_t prev;
        class_t prev2;
        logic   ri_parity;
        logic   transparent_seen;
    } ctx_t;

    function automatic logic is_ah_letter(input class_t c);
        return c inside {CLS_ALETTER, CLS_HEBREW};
    endfunction

    function automatic logic is_mid_letter_any(input class_t c);
        return c inside {CLS_MIDLETTER, CLS_MIDNUMLET, CLS_SQ};
    endfunction

    function automatic logic is_mid_num_any(input class_t c);
        return c inside {CLS_MIDNUM, CLS_MIDNUMLET, CLS_SQ};
    endfunction

    function automatic logic is_skip_class(input class_t c);
        return c inside {CLS_EXTEND, CLS_FORMAT, CLS_ZWJ};
    endfunction

    function automatic logic is_line_end(input class_t c);
        return c inside {CLS_NEWLINE, CLS_CR, CLS_LF};
    endfunction

endpackage

`default_nettype wire

>>> sv/uwbd_rules.sv
// Word-break rule network: next context and break decision for one codepoint.
`default_nettype none

module uwbd_rules (
    input  wire uwbd_pkg::ctx_t   ctx,
    input  wire                   command,
    input  wire uwbd_pkg::class_t cls_in,
    input  wire                   pictographic,
    input  wire uwbd_pkg::class_t look,
    output uwbd_pkg::ctx_t        ctx_next,
    output logic                  breakable
);
    import uwbd_pkg::*;

    class_t b;
    class_t a;
    class_t pp;
    logic   keep;
    ctx_t   adv;

    always_comb begin
        // Codes past the last class count as Other.
        b  = (cls_in > CLS_WSEGSPACE) ? CLS_OTHER : cls_in;
        a  = ctx.prev;
        pp = ctx.prev2;

        adv.raw_prev         = b;
        adv.prev             = b;
        adv.prev2            = ctx.prev;
        adv.ri_parity        = (b == CLS_RI) ? ~ctx.ri_parity : 1'b0;
        adv.transparent_seen = 1'b0;

        keep = 1'b0;
        if (a == CLS_WSEGSPACE && b == CLS_WSEGSPACE && !ctx.transparent_seen) keep = 1'b1;
        if (is_ah_letter(a) && is_ah_letter(b)) keep = 1'b1;
        if (is_ah_letter(a) && is_mid_letter_any(b) && is_ah_letter(look)) keep = 1'b1;
        if (is_mid_letter_any(a) && is_ah_letter(b) && is_ah_letter(pp)) keep = 1'b1;
        if (a == CLS_HEBREW && b == CLS_SQ) keep = 1'b1;
        if (a == CLS_HEBREW && b == CLS_DQ && look == CLS_HEBREW) keep = 1'b1;
        if (a == CLS_DQ && b == CLS_HEBREW && pp == CLS_HEBREW) keep = 1'b1;
        if (a == CLS_NUMERIC && b == CLS_NUMERIC) keep = 1'b1;
        if (is_ah_letter(a) && b == CLS_NUMERIC) keep = 1'b1;
        if (a == CLS_NUMERIC && is_ah_letter(b)) keep = 1'b1;
        if (is_mid_num_any(a) && b == CLS_NUMERIC && pp == CLS_NUMERIC) keep = 1'b1;
        if (a == CLS_NUMERIC && is_mid_num_any(b) && look == CLS_NUMERIC) keep = 1'b1;
        if (a == CLS_KATAKANA && b == CLS_KATAKANA) keep = 1'b1;
        if (b == CLS_EXTNUMLET && (is_ah_letter(a) || a == CLS_NUMERIC
                || a == CLS_KATAKANA || a == CLS_EXTNUMLET)) keep = 1'b1;
        if (a == CLS_EXTNUMLET && (is_ah_letter(b) || b == CLS_NUMERIC
                || b == CLS_KATAKANA)) keep = 1'b1;
        if (a == CLS_RI && b == CLS_RI && ctx.ri_parity) keep = 1'b1;

        ctx_next  = ctx;
        breakable = 1'b0;

        if (command == CMD_BEGIN) begin
            ctx_next.raw_prev         = b;
            ctx_next.prev2            = CLS_OTHER;
            ctx_next.transparent_seen = 1'b0;
            if (is_skip_class(b)) begin
                ctx_next.prev      = CLS_OTHER;
                ctx_next.ri_parity = 1'b0;
            end else begin
                ctx_next.prev      = b;
                ctx_next.ri_parity = (b == CLS_RI);
            end
        end else if (ctx.raw_prev == CLS_CR && b == CLS_LF) begin
            ctx_next = adv;
        end else if (is_line_end(ctx.raw_prev)) begin
            breakable = 1'b1;
            if (is_skip_class(b)) begin
                // Extenders after a line end attach to nothing.
                ctx_next.raw_prev  = b;
                ctx_next.prev      = CLS_OTHER;
                ctx_next.prev2     = CLS_OTHER;
                ctx_next.ri_parity = 1'b0;
            end else begin
                ctx_next = adv;
            end
        end else if (is_line_end(b)) begin
            ctx_next  = adv;
            breakable = 1'b1;
        end else if (ctx.raw_prev == CLS_ZWJ && pictographic) begin
            ctx_next = adv;
        end else if (is_skip_class(b)) begin
            ctx_next.raw_prev         = b;
            ctx_next.transparent_seen = 1'b1;
        end else begin
            ctx_next  = adv;
            breakable = ~keep;
        end
    end

endmodule

`default_nettype wire

>>> sv/unicode_word_break_detector_unit.sv
// Top level of the word-break detector: input register, rule network, result register.
// A next beat passes the input register and then the result register before m_tvalid.
// Throughput: one codepoint per cycle unless a full result register waits on m_tready;
// the rule network between the input and result registers is the only work.
// Reset (aresetn low, synchronous): both stages empty and the context returns to Other
// with parity and the transparent flag cleared.
`default_nettype none

module unicode_word_break_detector_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: current_class[4:0], pictographic[5],
    // lookahead_class[10:6], zero fill [15:11].
    input  wire  [uwbd_pkg::TDATA_IN_W-1:0] s_tdata,
    // s_tuser: command[0].
    input  wire  [0:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata, lowest bit up: breakable[0], zero fill [7:1].
    output logic [7:0]  m_tdata
);
    import uwbd_pkg::*;

    // Input stage. It holds one beat; the beat leaves when the result
    // register can take its result (begin beats make no result and always leave).
    logic   in_valid_reg;
    logic   in_valid_next;
    logic   in_cmd_reg;
    class_t in_cls_reg;
    logic   in_pict_reg;
    class_t in_look_reg;

    // Running context of the text.
    ctx_t ctx_reg;
    ctx_t ctx_next;

    // Result stage.
    logic out_valid_reg;
    logic out_valid_next;
    logic out_brk_reg;

    logic rule_brk;
    logic stage_fire;
    logic s_fire;

    uwbd_rules u_rules (
        .ctx          (ctx_reg),
        .command      (in_cmd_reg),
        .cls_in       (in_cls_reg),
        .pictographic (in_pict_reg),
        .look         (in_look_reg),
        .ctx_next     (ctx_next),
        .breakable    (rule_brk)
    );

    // The input stage may hand over when it is full and either the beat is a
    // begin or the result register is free or being drained this cycle.
    assign stage_fire = in_valid_reg
                      && (in_cmd_reg == CMD_BEGIN || !out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || stage_fire;
    assign s_fire     = s_tvalid && s_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (stage_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = (stage_fire && in_cmd_reg == CMD_NEXT) ? 1'b1
                          : ((out_valid_reg && m_tready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= '{raw_prev: CLS_OTHER, prev: CLS_OTHER, prev2: CLS_OTHER,
                               ri_parity: 1'b0, transparent_seen: 1'b0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (stage_fire) begin
                ctx_reg <= ctx_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg  <= s_tuser[0];
            in_cls_reg  <= s_tdata[4:0];
            in_pict_reg <= s_tdata[5];
            in_look_reg <= s_tdata[10:6];
        end
        if (stage_fire && in_cmd_reg == CMD_NEXT) begin
            out_brk_reg <= rule_brk;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W - 1){1'b0}}, out_brk_reg};

endmodule

`default_nettype wire
